[rtl/mexp_pkg.sv]
// package for the modular exponentiation core: data width, word type and
// the request / response structs of the shared modular multiplier
// no dependencies
`default_nettype none

package mexp_pkg;

    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned CNT_W      = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // start pulse and operands towards the multiplier
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
        word_t m;
    } mm_req_t;

    // completion pulse and reduced product back from the multiplier
    typedef struct packed {
        logic  done;
        word_t prod;
    } mm_rsp_t;

endpackage

`default_nettype wire

[rtl/mexp_modmul.sv]
// shift-and-add modular multiplier, one bit of b per cycle, msb first
// computes a * b mod m for a < m, m nonzero, any b; depends on mexp_pkg
`default_nettype none

module mexp_modmul (
    input  wire              clk,
    input  wire              rst_n,
    input  mexp_pkg::mm_req_t req,
    output mexp_pkg::mm_rsp_t rsp
);

    mexp_pkg::word_t acc_reg, acc_next;
    mexp_pkg::word_t a_reg;
    mexp_pkg::word_t b_reg;
    mexp_pkg::word_t m_reg;
    mexp_pkg::cnt_t  cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [mexp_pkg::DATA_WIDTH:0] dbl;
    logic [mexp_pkg::DATA_WIDTH:0] dbl_r;
    logic [mexp_pkg::DATA_WIDTH:0] sum;
    logic [mexp_pkg::DATA_WIDTH:0] sum_r;
    logic [mexp_pkg::DATA_WIDTH:0] m_ext;

    // double and reduce, then add a and reduce again when the top bit of b is set
    always_comb
    begin
        m_ext = {1'b0, m_reg};
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum   = {1'b0, dbl_r[mexp_pkg::DATA_WIDTH-1:0]} + {1'b0, a_reg};
        sum_r = (sum >= m_ext) ? (sum - m_ext) : sum;
        if (b_reg[mexp_pkg::DATA_WIDTH-1])
        begin
            acc_next = sum_r[mexp_pkg::DATA_WIDTH-1:0];
        end
        else
        begin
            acc_next = dbl_r[mexp_pkg::DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mexp_pkg::CNT_W'(mexp_pkg::DATA_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - mexp_pkg::CNT_W'(1);
                if (cnt_reg == mexp_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
            m_reg   <= req.m;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[mexp_pkg::DATA_WIDTH-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire

[rtl/modular_exponentiation_core.sv]
// top level of the modular exponentiation core: sequencer, operand
// registers and output register around the shared multiplier
// depends on mexp_pkg and mexp_modmul
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | sink      | in_valid/in_ready  | base_value, exponent_value, modulus_value
//  out     | source    | out_valid/out_ready| power_result, modulus_error
//
// one transfer in at a time; in_ready is high only while the sequencer idles
// every modular product runs on the one shared shift-and-add multiplier,
// and the item runs one reduction of the base, one product per set
// exponent bit and one square per exponent bit below the top set bit,
// plus a pass through the decision state S_STEP for each of those bits
// special cases (zero modulus, zero base, zero exponent) skip the multiplier
// a stalled output register holds its transfer; the sequencer waits for it
// asynchronous active-low reset clears the sequencer and the output valid
`default_nettype none

module modular_exponentiation_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [mexp_pkg::DATA_WIDTH-1:0] base_value,
    input  wire  [mexp_pkg::DATA_WIDTH-1:0] exponent_value,
    input  wire  [mexp_pkg::DATA_WIDTH-1:0] modulus_value,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [mexp_pkg::DATA_WIDTH-1:0] power_result,
    output logic                    modulus_error
);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input transfer
    localparam logic [2:0] S_RED  = 3'd1;  // reducing the base modulo m
    localparam logic [2:0] S_STEP = 3'd2;  // looking at the low exponent bit
    localparam logic [2:0] S_MUL  = 3'd3;  // acc = acc * sq mod m
    localparam logic [2:0] S_SQR  = 3'd4;  // sq = sq * sq mod m
    localparam logic [2:0] S_OUT  = 3'd5;  // handing the result over

    logic [2:0] state_reg, state_next;

    mexp_pkg::word_t exp_reg, exp_next;
    mexp_pkg::word_t acc_reg, acc_next;
    mexp_pkg::word_t sq_reg,  sq_next;
    mexp_pkg::word_t m_reg,   m_next;
    logic            err_reg, err_next;

    mexp_pkg::word_t res_reg;
    logic            res_err_reg;
    logic            out_valid_reg;

    mexp_pkg::mm_req_t mm_req;
    mexp_pkg::mm_rsp_t mm_rsp;

    logic accept;
    logic out_free;
    logic exp_rest_zero;

    assign accept        = in_valid && (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || out_ready;
    // nothing left above the current bit, so no further square is needed
    assign exp_rest_zero = (exp_reg[mexp_pkg::DATA_WIDTH-1:1] == '0);

    mexp_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    // sequencer: decides the next product and routes operands to the unit
    always_comb
    begin
        state_next   = state_reg;
        exp_next     = exp_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        m_next       = m_reg;
        err_next     = err_reg;
        mm_req.start = 1'b0;
        mm_req.a     = acc_reg;
        mm_req.b     = sq_reg;
        mm_req.m     = m_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    exp_next = exponent_value;
                    m_next   = modulus_value;
                    err_next = 1'b0;
                    if (modulus_value == '0)
                    begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (base_value == '0)
                    begin
                        acc_next   = '0;
                        state_next = S_OUT;
                    end
                    else if (exponent_value == '0)
                    begin
                        // one without reduction, even for a modulus of one
                        acc_next   = mexp_pkg::DATA_WIDTH'(1);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // acc starts at 1 mod m; base mod m = (1 mod m) * base
                        acc_next     = (modulus_value == mexp_pkg::DATA_WIDTH'(1)) ?
                                       '0 : mexp_pkg::DATA_WIDTH'(1);
                        mm_req.start = 1'b1;
                        mm_req.a     = acc_next;
                        mm_req.b     = base_value;
                        mm_req.m     = modulus_value;
                        state_next   = S_RED;
                    end
                end
            end

            S_RED:
            begin
                if (mm_rsp.done)
                begin
                    sq_next    = mm_rsp.prod;
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                mm_req.start = 1'b1;
                if (exp_reg[0])
                begin
                    mm_req.a   = acc_reg;
                    mm_req.b   = sq_reg;
                    state_next = S_MUL;
                end
                else
                begin
                    mm_req.a   = sq_reg;
                    mm_req.b   = sq_reg;
                    state_next = S_SQR;
                end
            end

            S_MUL:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.prod;
                    if (exp_rest_zero)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        mm_req.start = 1'b1;
                        mm_req.a     = sq_reg;
                        mm_req.b     = sq_reg;
                        state_next   = S_SQR;
                    end
                end
            end

            S_SQR:
            begin
                if (mm_rsp.done)
                begin
                    sq_next    = mm_rsp.prod;
                    exp_next   = {1'b0, exp_reg[mexp_pkg::DATA_WIDTH-1:1]};
                    state_next = S_STEP;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers and output payload
    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        m_reg   <= m_next;
        err_reg <= err_next;
        if ((state_reg == S_OUT) && out_free)
        begin
            res_reg     <= acc_reg;
            res_err_reg <= err_reg;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign power_result  = res_reg;
    assign modulus_error = res_err_reg;

endmodule

`default_nettype wire

[rtl/mexp_checker.sv]
// port-level checker for the modular exponentiation core, bound to the top
// depends on mexp_pkg and modular_exponentiation_core
`default_nettype none

module mexp_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             in_valid,
    input wire                             in_ready,
    input wire [mexp_pkg::DATA_WIDTH-1:0]  base_value,
    input wire [mexp_pkg::DATA_WIDTH-1:0]  exponent_value,
    input wire [mexp_pkg::DATA_WIDTH-1:0]  modulus_value,
    input wire                             out_valid,
    input wire                             out_ready,
    input wire [mexp_pkg::DATA_WIDTH-1:0]  power_result,
    input wire                             modulus_error
);

    typedef struct packed {
        mexp_pkg::word_t base;
        mexp_pkg::word_t expo;
        mexp_pkg::word_t modulus;
    } operands_t;

    operands_t  incoming;
    operands_t  head_q;
    operands_t  next_q;
    logic [1:0] count_q;
    logic       in_xfer;
    logic       out_xfer;
    logic       fill_head;

    assign incoming  = '{base: base_value, expo: exponent_value, modulus: modulus_value};
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    // at most one item in the sequencer and one in the output register
    assign fill_head = (count_q == 2'd0) || ((count_q == 2'd1) && out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_q <= '0;
        end
        else
        begin
            count_q <= count_q + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    // operands of the oldest item not yet handed over sit in head_q
    always_ff @(posedge clk)
    begin
        if (in_xfer && fill_head)
        begin
            head_q <= incoming;
        end
        else if (out_xfer)
        begin
            head_q <= next_q;
        end
        if (in_xfer && !fill_head)
        begin
            next_q <= incoming;
        end
    end

    // one item at a time: the input closes after a transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still open after transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(power_result) && $stable(modulus_error)))
        else $error("stalled result changed");

    // error flag follows the modulus of the item
    a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((modulus_error == 1'b1) == (head_q.modulus == '0)))
        else $error("error flag does not match modulus");

    // reduced result stays below the modulus, error gives zero
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (head_q.expo != '0 || head_q.base == '0)) |->
            ((modulus_error && power_result == '0) ||
             (!modulus_error && power_result < head_q.modulus)))
        else $error("result out of range");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .base_value     (base_value),
    .exponent_value (exponent_value),
    .modulus_value  (modulus_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .power_result   (power_result),
    .modulus_error  (modulus_error)
);

`default_nettype wire

[tb/sv/modular_exponentiation_core_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for modular_exponentiation_core: corner operands first, then random
// operands under bursty input and stalling output, all checked against a square-and-multiply model
// depends on mexp_pkg and the core rtl
module modular_exponentiation_core_tb;

    typedef mexp_pkg::word_t word_t;

    localparam int unsigned DATA_WIDTH      = mexp_pkg::DATA_WIDTH;
    localparam int unsigned RANDOM_ITEMS    = 1100;
    // long enough for the core to fill up behind a stalled output register
    localparam int unsigned HOLD_OFF_CYCLES = 4000;
    // cycles without any transfer before the run is declared hung
    // (an item can take roughly 64 products plus the hold-off)
    localparam int unsigned IDLE_LIMIT      = 40000;
    // quiet time after the last result, covers the slowest possible item
    localparam int unsigned DRAIN_CYCLES    = 2500;
    localparam word_t       WORD_MAX        = '1;

    // receiver behaviour between long hold-offs
    typedef enum int unsigned {
        ALWAYS_READY,
        MOSTLY_READY,
        MOSTLY_STALLED,
        PATTERNED
    } stall_mode_t;

    typedef struct packed {
        word_t power;
        logic  err;
    } expected_power_t;

    // holds the predicted results in transfer order and compares each result transfer
    class modexp_scoreboard;
        expected_power_t pending_powers[$];
        int unsigned     mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // base ** exponent mod modulus, with the special cases of the core
        function expected_power_t predict_power(word_t b, word_t e, word_t m);
            expected_power_t            r;
            logic [2*DATA_WIDTH-1:0]    m_wide;
            logic [2*DATA_WIDTH-1:0]    acc;
            logic [2*DATA_WIDTH-1:0]    sq;
            r.err   = 1'b0;
            r.power = '0;
            if (m == '0)
            begin
                r.err = 1'b1;
                return r;
            end
            if (b == '0)
                return r;
            if (e == '0)
            begin
                // no reduction here, so a modulus of one still gives one
                r.power = word_t'(1);
                return r;
            end
            m_wide = m;
            acc    = 1;
            acc    = acc % m_wide;
            sq     = b;
            sq     = sq % m_wide;
            // both operands stay below the modulus, so every product fits the double width
            for (int i = 0; i < DATA_WIDTH; i++)
            begin
                if (e[i])
                    acc = (acc * sq) % m_wide;
                sq = (sq * sq) % m_wide;
            end
            r.power = acc[DATA_WIDTH-1:0];
            return r;
        endfunction

        function void note_operands(word_t b, word_t e, word_t m);
            pending_powers.push_back(predict_power(b, e, m));
        endfunction

        function void check_power(word_t p, logic err);
            expected_power_t want;
            if (pending_powers.size() == 0)
            begin
                $display("%0t: result with none expected: power_result %0h modulus_error %0b",
                         $time, p, err);
                mismatch_count++;
                return;
            end
            want = pending_powers.pop_front();
            if (p !== want.power)
            begin
                $display("%0t: power_result expected %0h actual %0h", $time, want.power, p);
                mismatch_count++;
            end
            if (err !== want.err)
            begin
                $display("%0t: modulus_error expected %0b actual %0b", $time, want.err, err);
                mismatch_count++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_powers.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    word_t  base_value;
    word_t  exponent_value;
    word_t  modulus_value;
    logic   out_valid;
    logic   out_ready;
    word_t  power_result;
    logic   modulus_error;

    modexp_scoreboard sb;

    // items left in the current input burst before the sender idles
    int unsigned burst_left;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int unsigned hold_requests;
    int unsigned idle_cycles = 0;

    modular_exponentiation_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .modulus_value  (modulus_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .power_result   (power_result),
        .modulus_error  (modulus_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // both channels sampled at the rising edge, before any update of that edge lands
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_operands(base_value, exponent_value, modulus_value);
        if (rst_n && out_valid && out_ready)
            sb.check_power(power_result, modulus_error);
    end

    // hang detection: counts cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("modular_exponentiation_core test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver: changes stall mode at random intervals, and on request
    // holds off for a long stretch while the sender keeps offering
    initial
    begin
        int unsigned  hold_left;
        int unsigned  holds_served;
        int unsigned  mode_left;
        stall_mode_t  mode;
        logic [15:0]  pattern;
        out_ready    = 1'b0;
        hold_left    = 0;
        holds_served = 0;
        mode_left    = 0;
        mode         = ALWAYS_READY;
        pattern      = '1;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 400);
                pattern   = 16'($urandom()) | 16'd1;
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    ALWAYS_READY:   out_ready <= 1'b1;
                    MOSTLY_READY:   out_ready <= ($urandom_range(0, 3) != 0);
                    MOSTLY_STALLED: out_ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        out_ready <= pattern[0];
                        pattern   = {pattern[0], pattern[15:1]};
                    end
                endcase
            end
        end
    end

    // offers one item and returns at the edge of its transfer, or after the gap; valid stays up
    // into the next item unless the burst ends here and a gap follows
    task automatic send_operands(input word_t b, input word_t e, input word_t m);
        int unsigned gap;
        in_valid       <= 1'b1;
        base_value     <= b;
        exponent_value <= e;
        modulus_value  <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 30);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // sender pause until every predicted result has come back
    // one edge first so that a transfer at the current edge is already noted
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // mostly short exponents to keep the run short, a share of full-width ones,
    // and a steady sprinkling of the zero cases and tiny or huge moduli
    task automatic send_random_item();
        int unsigned pick;
        int unsigned width;
        word_t       b;
        word_t       e;
        word_t       m;
        b     = $urandom();
        e     = $urandom();
        m     = $urandom();
        pick  = $urandom_range(0, 99);
        if (pick < 65)
            width = $urandom_range(1, 8);
        else if (pick < 85)
            width = $urandom_range(9, 16);
        else
            width = DATA_WIDTH;
        e    = e >> (DATA_WIDTH - width);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            m = '0;
        else if (pick < 8)
            b = '0;
        else if (pick < 12)
            e = '0;
        else if (pick < 16)
        begin
            case ($urandom_range(0, 3))
                0:       m = word_t'(1);
                1:       m = word_t'(2);
                2:       m = WORD_MAX;
                default: m = word_t'(1) << (DATA_WIDTH - 1);
            endcase
        end
        else
        begin
            case ($urandom_range(0, 3))
                0, 1:    m = m;
                2:       m = word_t'($urandom_range(1, 1000));
                default: m = WORD_MAX - word_t'($urandom_range(0, 1000));
            endcase
        end
        send_operands(b, e, m);
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        base_value     = '0;
        exponent_value = '0;
        modulus_value  = '0;
        burst_left     = 1;
        hold_requests  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero modulus flags an error whatever the other operands are
        send_operands('0, '0, '0);
        send_operands(WORD_MAX, WORD_MAX, '0);
        send_operands(word_t'(5), '0, '0);
        // zero base gives zero, even with a zero exponent
        send_operands('0, '0, word_t'(7));
        send_operands('0, '0, word_t'(1));
        send_operands('0, WORD_MAX, WORD_MAX);
        // zero exponent gives one unreduced, even for a modulus of one
        send_operands(word_t'(5), '0, word_t'(1));
        send_operands(WORD_MAX, '0, WORD_MAX);
        send_operands(word_t'(3), '0, word_t'(7));
        // modulus of one with a real exponent reduces to zero
        send_operands(word_t'(5), word_t'(3), word_t'(1));
        // base at or above the modulus
        send_operands(WORD_MAX, word_t'(3), word_t'(7));
        send_operands(word_t'(7), word_t'(5), word_t'(7));
        // full-width operands, where a plain 32-bit product would overflow
        send_operands(WORD_MAX, WORD_MAX, WORD_MAX);
        send_operands(word_t'(2), WORD_MAX, WORD_MAX);
        send_operands(WORD_MAX - 1, WORD_MAX, WORD_MAX);
        send_operands(word_t'(2), word_t'(31), WORD_MAX);
        send_operands(word_t'(2), word_t'(32), WORD_MAX);
        send_operands(word_t'(3), word_t'(1) << (DATA_WIDTH - 1), WORD_MAX - 4);
        send_operands(word_t'(1), WORD_MAX, (word_t'(1) << (DATA_WIDTH - 1)) + 1);
        send_operands(32'h1234_5678, 32'hDEAD_BEEF, (word_t'(1) << (DATA_WIDTH - 1)) + 1);
        send_operands(word_t'(2), word_t'(10), word_t'(1000));
        send_operands(WORD_MAX, word_t'(2), word_t'(1) << (DATA_WIDTH - 1));
        send_operands(32'hAAAA_AAAA, 32'h5555_5555, WORD_MAX - 1);
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // long receiver hold-off while items keep coming, so the input stalls
            if (n == 300)
                hold_requests <= hold_requests + 1;
            if (n == 700)
                wait_for_drain();
            send_random_item();
        end

        wait_for_drain();
        // let any stray extra result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("modular_exponentiation_core test passed");
        else
            $display("modular_exponentiation_core test failed");
        $finish;
    end

endmodule

[modular_exponentiation_core.f]
rtl/mexp_pkg.sv
rtl/mexp_modmul.sv
rtl/modular_exponentiation_core.sv
rtl/mexp_checker.sv
tb/sv/modular_exponentiation_core_tb.sv
